// ===== hw/rtl/vibp_pkg.sv =====
`timescale 1ns / 1ps

package vibp_pkg;

    // 7-bit character codes used by the parser
    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_HT    = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_VT    = 7'h0B;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_SEP   = 7'h13;
    localparam logic [6:0] CH_CAN   = 7'h18;
    localparam logic [6:0] CH_ESC   = 7'h1B;
    localparam logic [6:0] CH_RS    = 7'h1E;
    localparam logic [6:0] CH_US    = 7'h1F;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ESC3  = 7'h3B;
    localparam logic [6:0] CH_ESC1  = 7'h40;
    localparam logic [6:0] CH_DEL   = 7'h7F;

    // Number of parameter bytes in the three-byte escape form
    localparam logic [1:0] ESC3_LEN = 2'd3;
    // Bytes held before the last one of the three-byte form arrives
    localparam logic [1:0] CAP_LAST = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_COLL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_CTRL = 2'd1,
        KIND_SEP  = 2'd2,
        KIND_ESC  = 2'd3
    } kind_t;

    // Control state of the parser
    typedef struct packed {
        phase_t     phase;
        logic       sep_pending;
        logic [1:0] cap_count;
    } ctl_t;

    // One parsed event
    typedef struct packed {
        kind_t      kind;
        logic [6:0] code;
        logic [2:0] sep_row;
        logic [3:0] sep_col;
        logic [1:0] esc_count;
        logic [6:0] esc_byte0;
        logic [6:0] esc_byte1;
        logic [6:0] esc_byte2;
    } evt_t;

    // Capture write request toward the escape byte store
    typedef struct packed {
        logic       we;
        logic       idx;
        logic [6:0] data;
    } cap_wr_t;

endpackage

// ===== hw/rtl/vibp_decode.sv =====
`timescale 1ns / 1ps

// Combinational classifier: one byte plus current state in, next state and
// an optional event out.
module vibp_decode (
    input  logic [7:0]       rx_byte,
    input  vibp_pkg::ctl_t   ctl,
    input  logic [6:0]       cap0,
    input  logic [6:0]       cap1,
    output vibp_pkg::ctl_t   ctl_next,
    output vibp_pkg::cap_wr_t cap_wr,
    output logic             emit,
    output vibp_pkg::evt_t   evt
);

    logic [6:0] c;

    // parity bit dropped
    assign c = rx_byte[6:0];

    always_comb begin
        ctl_next    = ctl;
        cap_wr.we   = 1'b0;
        cap_wr.idx  = ctl.cap_count[0];
        cap_wr.data = c;
        emit        = 1'b0;
        evt         = '0;

        unique case (ctl.phase)
            vibp_pkg::PH_ESC: begin
                if (c == vibp_pkg::CH_ESC3) begin
                    ctl_next.phase     = vibp_pkg::PH_COLL;
                    ctl_next.cap_count = 2'd0;
                end else begin
                    ctl_next.phase = vibp_pkg::PH_IDLE;
                    // one-byte escape; anything below 0x40 is dropped
                    if (c >= vibp_pkg::CH_ESC1) begin
                        emit      = 1'b1;
                        evt.kind  = vibp_pkg::KIND_ESC;
                        evt.code  = c;
                    end
                end
            end
            vibp_pkg::PH_COLL: begin
                if (ctl.cap_count < vibp_pkg::CAP_LAST) begin
                    cap_wr.we          = 1'b1;
                    ctl_next.cap_count = ctl.cap_count + 2'd1;
                end else begin
                    emit               = 1'b1;
                    evt.kind           = vibp_pkg::KIND_ESC;
                    evt.code           = vibp_pkg::CH_ESC3;
                    evt.esc_count      = vibp_pkg::ESC3_LEN;
                    evt.esc_byte0      = cap0;
                    evt.esc_byte1      = cap1;
                    evt.esc_byte2      = c;
                    ctl_next.phase     = vibp_pkg::PH_IDLE;
                    ctl_next.cap_count = 2'd0;
                end
            end
            default: begin
                // idle, and the unused phase code folds to idle
                ctl_next.phase = vibp_pkg::PH_IDLE;
                if (ctl.sep_pending) begin
                    ctl_next.sep_pending = 1'b0;
                    emit        = 1'b1;
                    evt.kind    = vibp_pkg::KIND_SEP;
                    evt.code    = c;
                    evt.sep_row = c[6:4];
                    evt.sep_col = c[3:0];
                end else begin
                    unique case (c) inside
                        vibp_pkg::CH_HT, vibp_pkg::CH_VT, vibp_pkg::CH_CAN,
                        vibp_pkg::CH_RS, vibp_pkg::CH_US, vibp_pkg::CH_DEL: begin
                            // editing controls: consumed silently
                        end
                        vibp_pkg::CH_ESC: begin
                            ctl_next.phase = vibp_pkg::PH_ESC;
                        end
                        vibp_pkg::CH_SEP: begin
                            ctl_next.sep_pending = 1'b1;
                        end
                        vibp_pkg::CH_BS, vibp_pkg::CH_LF, vibp_pkg::CH_CR: begin
                            emit     = 1'b1;
                            evt.kind = vibp_pkg::KIND_CHAR;
                            evt.code = c;
                        end
                        default: begin
                            emit     = 1'b1;
                            evt.kind = (c < vibp_pkg::CH_SPACE) ? vibp_pkg::KIND_CTRL
                                                                : vibp_pkg::KIND_CHAR;
                            evt.code = c;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/videotex_input_byte_parser.sv =====
`timescale 1ns / 1ps

// Received-byte parser for a videotex terminal link. Each byte taken on the
// s_ channel has its parity bit stripped and is classified into at most one
// event (character, control, separator or escape sequence) on the m_ channel;
// ESC, SEP, editing controls, leading escape bytes and one-byte escapes below
// 0x40 give no event. A byte passes an input register, one level of decode
// logic and an output register; a byte is taken every cycle and its event is
// registered as it leaves the input; only back-pressure on m_ready slows it.
module videotex_input_byte_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_kind,
    output logic [6:0] m_event_code,
    output logic [2:0] m_sep_row,
    output logic [3:0] m_sep_col,
    output logic [1:0] m_esc_count,
    output logic [6:0] m_esc_byte0,
    output logic [6:0] m_esc_byte1,
    output logic [6:0] m_esc_byte2
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    vibp_pkg::ctl_t    ctl_reg;
    vibp_pkg::ctl_t    ctl_next;
    logic [6:0]        cap_reg [2];
    vibp_pkg::cap_wr_t cap_wr;
    logic              emit;
    vibp_pkg::evt_t    evt;
    logic              out_valid_reg;
    vibp_pkg::evt_t    out_evt_reg;
    logic              advance;

    // Held byte moves on whenever the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    vibp_decode u_decode (
        .rx_byte  (in_byte_reg),
        .ctl      (ctl_reg),
        .cap0     (cap_reg[0]),
        .cap1     (cap_reg[1]),
        .ctl_next (ctl_next),
        .cap_wr   (cap_wr),
        .emit     (emit),
        .evt      (evt)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase       <= vibp_pkg::PH_IDLE;
            ctl_reg.sep_pending <= 1'b0;
            ctl_reg.cap_count   <= 2'd0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
        end
    end

    // Escape parameter bytes, always written before read
    always_ff @(posedge aclk) begin
        if (advance && cap_wr.we) begin
            cap_reg[cap_wr.idx] <= cap_wr.data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            out_evt_reg <= evt;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_kind = out_evt_reg.kind;
    assign m_event_code = out_evt_reg.code;
    assign m_sep_row    = out_evt_reg.sep_row;
    assign m_sep_col    = out_evt_reg.sep_col;
    assign m_esc_count  = out_evt_reg.esc_count;
    assign m_esc_byte0  = out_evt_reg.esc_byte0;
    assign m_esc_byte1  = out_evt_reg.esc_byte1;
    assign m_esc_byte2  = out_evt_reg.esc_byte2;

    // Capture count never goes past the two stored bytes
    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.cap_count != 2'd3)
        else $error("capture count out of range");

    // A pending separator only exists while the escape machine is idle
    a_sep_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.sep_pending |-> ctl_reg.phase == vibp_pkg::PH_IDLE)
        else $error("separator pending during escape");

    // ESC 0x3B starts a fresh collection
    a_coll_start: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl_reg.phase == vibp_pkg::PH_ESC
            && in_byte_reg[6:0] == vibp_pkg::CH_ESC3
        |=> ctl_reg.phase == vibp_pkg::PH_COLL && ctl_reg.cap_count == 2'd0)
        else $error("collection did not start");

    // Leading collected bytes produce no transaction
    a_coll_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl_reg.phase == vibp_pkg::PH_COLL
            && ctl_reg.cap_count != vibp_pkg::CAP_LAST
        |=> !out_valid_reg)
        else $error("event emitted while collecting");

endmodule
